>>> rtl/core/wvan_pkg.sv
// Shared types and constants of the windowed vector average block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package wvan_pkg;

   // Field widths of the sample and result channels.
   localparam int DATA_W     = 16;
   localparam int CFG_W      = 5;
   localparam int CFG_MAX    = (1 << CFG_W) - 1;
   localparam int UNIT_FRAC  = 14;

   // Square root: radicand is the sum of two 16-bit squares.
   localparam int RAD_W      = 2 * DATA_W;
   localparam int MAG_W      = RAD_W / 2;
   localparam int ROOT_STEPS = RAD_W / 2;

   // Window settings.
   localparam int WINDOW_MAX_DEF = 16;
   localparam int WINDOW_DEFAULT = 15;

   typedef struct packed {
      logic take;       // input transfer, latch the item
      logic clr_item;   // clear history for a clear item
      logic upd;        // push the latched sample into the window
      logic avg_go;     // start the mean division
      logic avg_take;   // latch the mean
      logic sq_x;       // square the x mean
      logic sq_y;       // square the y mean
      logic root_go;    // start the square root
      logic unit_go;    // start the unit vector division
      logic unit_take;  // latch the unit vector
      logic unit_zero;  // unit vector is zero
      logic out_load;   // load the output register
   } wvan_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic div_busy;
      logic root_busy;
      logic mag_zero;
      logic out_free;
   } wvan_sts_type;

endpackage

>>> rtl/core/wvan_req_if.sv
// Sample channel interface: valid/ready handshake with the sample payload.
// Depends on wvan_pkg for the field widths.
interface wvan_req_if import wvan_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic signed [DATA_W-1:0] sample_x;
   logic signed [DATA_W-1:0] sample_y;

   modport source (output valid, output func, output sample_x, output sample_y, input ready);
   modport sink   (input valid, input func, input sample_x, input sample_y, output ready);
endinterface

>>> rtl/core/wvan_rsp_if.sv
// Result channel interface: valid/ready handshake with the mean and unit vectors.
// Depends on wvan_pkg for the field widths.
interface wvan_rsp_if import wvan_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] avg_x;
   logic signed [DATA_W-1:0] avg_y;
   logic signed [DATA_W-1:0] unit_x;
   logic signed [DATA_W-1:0] unit_y;
   logic                     enough_history;

   modport source (output valid, output avg_x, output avg_y, output unit_x, output unit_y,
                   output enough_history, input ready);
   modport sink   (input valid, input avg_x, input avg_y, input unit_x, input unit_y,
                   input enough_history, output ready);
endinterface

>>> rtl/core/wvan_divu.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated once per vector component by the datapath.
module wvan_divu #(
   parameter int DVD_W = 30,
   parameter int DSR_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);
   localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DSR_W-1:0] rem_ff;
   logic [DSR_W-1:0] dsr_ff;

   logic [DSR_W:0]   rem_sh;
   logic             fits;
   logic [DSR_W-1:0] rem_in;

   // The remainder stays below the divisor, so the shifted value is below twice it.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DVD_W-1]};
      fits   = rem_sh >= {1'b0, dsr_ff};
      if (fits) begin
         rem_in = DSR_W'(rem_sh - {1'b0, dsr_ff});
      end else begin
         rem_in = rem_sh[DSR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

>>> rtl/core/wvan_ctrl.sv
// Controller state machine: sequences window update, mean division,
// squaring, square root and unit vector division. Depends on wvan_pkg.
module wvan_ctrl import wvan_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  wvan_sts_type sts,
   output wvan_cmd_type cmd
);
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CHECK     = 4'd1;
   localparam logic [3:0] ST_AVG_GO    = 4'd2;
   localparam logic [3:0] ST_AVG_WAIT  = 4'd3;
   localparam logic [3:0] ST_SQ_X      = 4'd4;
   localparam logic [3:0] ST_SQ_Y      = 4'd5;
   localparam logic [3:0] ST_ROOT_GO   = 4'd6;
   localparam logic [3:0] ST_ROOT_WAIT = 4'd7;
   localparam logic [3:0] ST_UNIT_GO   = 4'd8;
   localparam logic [3:0] ST_UNIT_WAIT = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.is_clear) begin
               cmd.clr_item = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.upd  = 1'b1;
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            cmd.avg_go = 1'b1;
            state_in   = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (!sts.div_busy) begin
               cmd.avg_take = 1'b1;
               state_in     = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            cmd.sq_y = 1'b1;
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            cmd.root_go = 1'b1;
            state_in    = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (!sts.root_busy) begin
               if (sts.mag_zero) begin
                  cmd.unit_zero = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_UNIT_GO;
               end
            end
         end
         ST_UNIT_GO: begin
            cmd.unit_go = 1'b1;
            state_in    = ST_UNIT_WAIT;
         end
         ST_UNIT_WAIT: begin
            if (!sts.div_busy) begin
               cmd.unit_take = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            // Wait until the output register can take the new result.
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> rtl/core/wvan_dp.sv
// Datapath: sample history memory, running sums, frame count, two divider
// lanes, squaring, square root and the output register. Depends on wvan_pkg, wvan_divu.
module wvan_dp import wvan_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CFG_W-1:0]         csr_wdata,
   input  logic                     req_func,
   input  logic signed [DATA_W-1:0] req_sample_x,
   input  logic signed [DATA_W-1:0] req_sample_y,
   input  wvan_cmd_type             cmd,
   output wvan_sts_type             sts,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_avg_x,
   output logic signed [DATA_W-1:0] rsp_avg_y,
   output logic signed [DATA_W-1:0] rsp_unit_x,
   output logic signed [DATA_W-1:0] rsp_unit_y,
   output logic                     rsp_enough_history
);
   localparam int WIN_LIM    = (WINDOW_MAX < CFG_MAX) ? WINDOW_MAX : CFG_MAX;
   localparam int SUM_W      = DATA_W + $clog2(WIN_LIM);
   localparam int SLOT_W     = $clog2(WINDOW_MAX);
   localparam int FR_W       = $clog2(WINDOW_MAX + 2);
   localparam int FR_SAT     = WINDOW_MAX + 1;
   localparam int UDV_W      = DATA_W + UNIT_FRAC;
   localparam int DVD_W      = (SUM_W > UDV_W) ? SUM_W : UDV_W;
   localparam int RCNT_W     = $clog2(ROOT_STEPS);
   localparam int REM_W      = MAG_W + 2;

   // Window register and history state.
   logic [CFG_W-1:0]         win_ff;
   logic [FR_W-1:0]          frames_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic signed [SUM_W-1:0]  sum_x_ff;
   logic signed [SUM_W-1:0]  sum_y_ff;
   logic [2*DATA_W-1:0]      hist_mem [WINDOW_MAX];
   logic [2*DATA_W-1:0]      rd_ff;

   // Latched item.
   logic                     func_ff;
   logic signed [DATA_W-1:0] smp_x_ff;
   logic signed [DATA_W-1:0] smp_y_ff;

   // Working results.
   logic signed [DATA_W-1:0] avg_x_ff;
   logic signed [DATA_W-1:0] avg_y_ff;
   logic signed [DATA_W-1:0] unit_x_ff;
   logic signed [DATA_W-1:0] unit_y_ff;
   logic [RAD_W-1:0]         sqa_ff;
   logic [RAD_W-1:0]         sqb_ff;

   // Square root unit.
   logic                     root_busy_ff;
   logic [RCNT_W-1:0]        rcnt_ff;
   logic [RAD_W-1:0]         rad_ff;
   logic [REM_W-1:0]         rrem_ff;
   logic [MAG_W-1:0]         root_ff;

   // Output register.
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_avg_x_ff;
   logic signed [DATA_W-1:0] rsp_avg_y_ff;
   logic signed [DATA_W-1:0] rsp_unit_x_ff;
   logic signed [DATA_W-1:0] rsp_unit_y_ff;
   logic                     rsp_enough_ff;

   logic [CFG_W-1:0]         win_raw;
   logic [CFG_W-1:0]         win_eff;
   logic                     old_used;
   logic signed [DATA_W-1:0] old_x;
   logic signed [DATA_W-1:0] old_y;
   logic [SLOT_W-1:0]        slot_in;
   logic [CFG_W-1:0]         avg_div;
   logic                     enough;
   logic [SUM_W-1:0]         abs_sum_x;
   logic [SUM_W-1:0]         abs_sum_y;
   logic [DATA_W-1:0]        abs_ax;
   logic [DATA_W-1:0]        abs_ay;
   logic [DATA_W-1:0]        abs_sel;
   logic [RAD_W-1:0]         sq_prod;
   logic                     div_start;
   logic [DVD_W-1:0]         dvd_x;
   logic [DVD_W-1:0]         dvd_y;
   logic [MAG_W-1:0]         dsr;
   logic                     busy_x;
   logic                     busy_y;
   logic [DVD_W-1:0]         quo_x;
   logic [DVD_W-1:0]         quo_y;
   logic [REM_W+1:0]         rrem_sh;
   logic [REM_W+1:0]         rtrial;
   logic                     rfits;
   logic                     hist_clr;

   always_comb begin
      win_raw = (win_ff == '0) ? CFG_W'(WINDOW_DEFAULT) : win_ff;
      win_eff = (int'(win_raw) > WINDOW_MAX) ? CFG_W'(WINDOW_MAX) : win_raw;
   end

   // A slot holds a live sample only once the window has been filled since the last clear.
   always_comb begin
      old_used = int'(frames_ff) >= int'(win_eff);
      old_x    = old_used ? signed'(rd_ff[DATA_W-1:0]) : '0;
      old_y    = old_used ? signed'(rd_ff[2*DATA_W-1:DATA_W]) : '0;
      if (int'(slot_ff) + 1 >= int'(win_eff)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
      if (int'(frames_ff) < int'(win_eff)) begin
         avg_div = CFG_W'(frames_ff);
      end else begin
         avg_div = win_eff;
      end
      enough = int'(frames_ff) > int'(win_eff);
   end

   assign hist_clr = csr_we || cmd.clr_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= CFG_W'(WINDOW_DEFAULT);
         frames_ff <= '0;
         slot_ff   <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
      end else begin
         if (csr_we) begin
            win_ff <= csr_wdata;
         end
         if (hist_clr) begin
            frames_ff <= '0;
            slot_ff   <= '0;
            sum_x_ff  <= '0;
            sum_y_ff  <= '0;
         end else if (cmd.upd) begin
            sum_x_ff <= sum_x_ff - SUM_W'(old_x) + SUM_W'(smp_x_ff);
            sum_y_ff <= sum_y_ff - SUM_W'(old_y) + SUM_W'(smp_y_ff);
            slot_ff  <= slot_in;
            if (int'(frames_ff) < FR_SAT) begin
               frames_ff <= frames_ff + 1'b1;
            end
         end
      end
   end

   // History memory: x in the low half, y in the high half.
   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         hist_mem[slot_ff] <= {smp_y_ff, smp_x_ff};
      end
      rd_ff <= hist_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         func_ff  <= req_func;
         smp_x_ff <= req_sample_x;
         smp_y_ff <= req_sample_y;
      end
   end

   // Divider lanes, shared between the mean and the unit vector.
   always_comb begin
      abs_sum_x = sum_x_ff[SUM_W-1] ? SUM_W'(-sum_x_ff) : SUM_W'(sum_x_ff);
      abs_sum_y = sum_y_ff[SUM_W-1] ? SUM_W'(-sum_y_ff) : SUM_W'(sum_y_ff);
      abs_ax    = avg_x_ff[DATA_W-1] ? DATA_W'(-avg_x_ff) : DATA_W'(avg_x_ff);
      abs_ay    = avg_y_ff[DATA_W-1] ? DATA_W'(-avg_y_ff) : DATA_W'(avg_y_ff);
      div_start = cmd.avg_go || cmd.unit_go;
      if (cmd.unit_go) begin
         dvd_x = DVD_W'({abs_ax, {UNIT_FRAC{1'b0}}});
         dvd_y = DVD_W'({abs_ay, {UNIT_FRAC{1'b0}}});
         dsr   = root_ff;
      end else begin
         dvd_x = DVD_W'(abs_sum_x);
         dvd_y = DVD_W'(abs_sum_y);
         dsr   = MAG_W'(avg_div);
      end
   end

   wvan_divu #(.DVD_W(DVD_W), .DSR_W(MAG_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_x),
      .divisor  (dsr),
      .busy     (busy_x),
      .quotient (quo_x)
   );

   wvan_divu #(.DVD_W(DVD_W), .DSR_W(MAG_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_y),
      .divisor  (dsr),
      .busy     (busy_y),
      .quotient (quo_y)
   );

   // Quotients are truncated magnitudes; the sign is put back afterwards.
   always_ff @(posedge clock) begin
      if (cmd.clr_item) begin
         avg_x_ff  <= '0;
         avg_y_ff  <= '0;
         unit_x_ff <= '0;
         unit_y_ff <= '0;
      end else begin
         if (cmd.avg_take) begin
            avg_x_ff <= sum_x_ff[SUM_W-1] ? -signed'(quo_x[DATA_W-1:0])
                                          : signed'(quo_x[DATA_W-1:0]);
            avg_y_ff <= sum_y_ff[SUM_W-1] ? -signed'(quo_y[DATA_W-1:0])
                                          : signed'(quo_y[DATA_W-1:0]);
         end
         if (cmd.unit_zero) begin
            unit_x_ff <= '0;
            unit_y_ff <= '0;
         end else if (cmd.unit_take) begin
            unit_x_ff <= avg_x_ff[DATA_W-1] ? -signed'(quo_x[DATA_W-1:0])
                                            : signed'(quo_x[DATA_W-1:0]);
            unit_y_ff <= avg_y_ff[DATA_W-1] ? -signed'(quo_y[DATA_W-1:0])
                                            : signed'(quo_y[DATA_W-1:0]);
         end
      end
   end

   // One multiplier squares x and then y.
   always_comb begin
      abs_sel = cmd.sq_y ? abs_ay : abs_ax;
      sq_prod = RAD_W'(abs_sel) * RAD_W'(abs_sel);
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_x) begin
         sqa_ff <= sq_prod;
      end
      if (cmd.sq_y) begin
         sqb_ff <= sq_prod;
      end
   end

   // Digit-by-digit floor square root, two radicand bits per cycle.
   always_comb begin
      rrem_sh = {rrem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      rtrial  = (REM_W + 2)'({root_ff, 2'b01});
      rfits   = rrem_sh >= rtrial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_busy_ff <= 1'b0;
         rcnt_ff      <= '0;
      end else if (cmd.root_go) begin
         root_busy_ff <= 1'b1;
         rcnt_ff      <= '0;
      end else if (root_busy_ff) begin
         rcnt_ff <= rcnt_ff + 1'b1;
         if (rcnt_ff == RCNT_W'(ROOT_STEPS - 1)) begin
            root_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.root_go) begin
         rad_ff  <= sqa_ff + sqb_ff;
         rrem_ff <= '0;
         root_ff <= '0;
      end else if (root_busy_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (rfits) begin
            rrem_ff <= REM_W'(rrem_sh - rtrial);
            root_ff <= {root_ff[MAG_W-2:0], 1'b1};
         end else begin
            rrem_ff <= REM_W'(rrem_sh);
            root_ff <= {root_ff[MAG_W-2:0], 1'b0};
         end
      end
   end

   // Output register lets the next item in while a result waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_avg_x_ff  <= avg_x_ff;
         rsp_avg_y_ff  <= avg_y_ff;
         rsp_unit_x_ff <= unit_x_ff;
         rsp_unit_y_ff <= unit_y_ff;
         rsp_enough_ff <= enough;
      end
   end

   always_comb begin
      sts.is_clear  = func_ff;
      sts.div_busy  = busy_x || busy_y;
      sts.root_busy = root_busy_ff;
      sts.mag_zero  = root_ff == '0;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_avg_x          = rsp_avg_x_ff;
   assign rsp_avg_y          = rsp_avg_y_ff;
   assign rsp_unit_x         = rsp_unit_x_ff;
   assign rsp_unit_y         = rsp_unit_y_ff;
   assign rsp_enough_history = rsp_enough_ff;
endmodule

>>> rtl/core/windowed_vector_average_normalize.sv
// Windowed vector average with normalization. Each transfer on the sample channel
// gives one result: the mean of the last window_length Q7.8 samples (truncated toward
// zero), its unit vector in Q1.14 and a flag once more frames than the window were seen.
// A push runs the bit-serial divider for the mean, then the bit-serial square root, then
// the divider again for the unit vector, which is skipped when the mean is zero; a clear
// item skips all three. No new transfer is taken until the result is loaded for output.
// Writing csr_wdata clears the history; it must happen only while the block is idle.
// Depends on wvan_pkg, wvan_req_if, wvan_rsp_if, wvan_ctrl and wvan_dp.
module windowed_vector_average_normalize import wvan_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   wvan_req_if.sink         req_ch,
   wvan_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata
);
   wvan_cmd_type cmd;
   wvan_sts_type sts;
   logic         req_ready;

   assign req_ch.ready = req_ready;

   wvan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wvan_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_func           (req_ch.func),
      .req_sample_x       (req_ch.sample_x),
      .req_sample_y       (req_ch.sample_y),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_avg_x          (rsp_ch.avg_x),
      .rsp_avg_y          (rsp_ch.avg_y),
      .rsp_unit_x         (rsp_ch.unit_x),
      .rsp_unit_y         (rsp_ch.unit_y),
      .rsp_enough_history (rsp_ch.enough_history)
   );
endmodule
